/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property with the checks suspended while reset is held.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/pee_pkg.sv */
// Shared types and constants of the precedence expression evaluator.
package pee_pkg;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;

    localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        TERM_LOAD,
        TERM_MUL,
        TERM_DIV
    } t_term_op;

    typedef struct packed {
        logic load_item;
        logic term_load;
        logic mul_start;
        logic mul_fin;
        logic div_zero;
        logic div_start;
        logic div_step;
        logic div_fin;
        logic set_mul;
        logic set_div;
        logic fold_sum;
        logic emit;
    } t_cmd;

    typedef struct packed {
        t_term_op   pend;
        logic [2:0] op;
        logic       x_zero;
        logic       div_last;
        logic       out_free;
    } t_status;

endpackage

/* src/precedence_expression_evaluator_core.sv */
// Evaluates + - * / expressions over signed fixed-point operands (FRAC_BITS fraction
// bits, 32 bits wide) with multiplicative operators binding first, left to right at
// both levels. Each input item carries one operand and the operator that follows it;
// an item whose operator is end (codes 4 to 7) yields one result with sticky overflow
// and divide-by-zero flags, and clears the expression. Steps saturate to 32 bits.
// An item's operand is loaded as the term, multiplied into it, or divided into it by the
// bit-serial divider, which produces one quotient bit per cycle over 32 + FRAC_BITS bits;
// a division by zero skips the divider, clears the term and sets the divide-by-zero flag.
// One item is in work at a time; a finished result waits in its output register while
// the next items are taken.
module precedence_expression_evaluator_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_operand_value,
    input  logic [2:0]         i_op_code,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_result_value,
    output logic               o_overflow_flag,
    output logic               o_div_zero_flag
);

    pee_pkg::t_cmd    cmd;
    pee_pkg::t_status status;

    pee_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pee_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_operand_value (i_operand_value),
        .i_op_code       (i_op_code),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_result_value  (o_result_value),
        .o_overflow_flag (o_overflow_flag),
        .o_div_zero_flag (o_div_zero_flag)
    );

endmodule

/* src/pee_ctrl.sv */
// Sequencer that steps each item through the fold of operand and term.
module pee_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pee_pkg::t_status  i_status,
    output pee_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FOLD,
        S_MULF,
        S_DIV,
        S_DIVF,
        S_TERM
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_FOLD;
                end
            end
            S_FOLD: begin
                unique case (i_status.pend)
                    pee_pkg::TERM_MUL: begin
                        o_cmd.mul_start = 1'b1;
                        n_state         = S_MULF;
                    end
                    pee_pkg::TERM_DIV: begin
                        if (i_status.x_zero) begin
                            o_cmd.div_zero = 1'b1;
                            n_state        = S_TERM;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_state         = S_DIV;
                        end
                    end
                    default: begin
                        o_cmd.term_load = 1'b1;
                        n_state         = S_TERM;
                    end
                endcase
            end
            S_MULF: begin
                o_cmd.mul_fin = 1'b1;
                n_state       = S_TERM;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_DIVF;
                end
            end
            S_DIVF: begin
                o_cmd.div_fin = 1'b1;
                n_state       = S_TERM;
            end
            S_TERM: begin
                unique case (i_status.op) inside
                    pee_pkg::OP_ADD, pee_pkg::OP_SUB: begin
                        o_cmd.fold_sum = 1'b1;
                        n_state        = S_IDLE;
                    end
                    pee_pkg::OP_MUL: begin
                        o_cmd.set_mul = 1'b1;
                        n_state       = S_IDLE;
                    end
                    pee_pkg::OP_DIV: begin
                        o_cmd.set_div = 1'b1;
                        n_state       = S_IDLE;
                    end
                    default: begin
                        // end of expression: hold until the result register is free
                        if (i_status.out_free) begin
                            o_cmd.emit = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/pee_dp.sv */
// Datapath: expression state, multiplier, bit-serial divider, adder, result register.
module pee_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pee_pkg::t_cmd       i_cmd,
    output pee_pkg::t_status    o_status,
    input  logic signed [31:0]  i_operand_value,
    input  logic [2:0]          i_op_code,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic signed [31:0]  o_result_value,
    output logic                o_overflow_flag,
    output logic                o_div_zero_flag
);

    localparam int DivW = 32 + FRAC_BITS;
    localparam int CntW = $clog2(DivW);

    // expression state
    logic signed [31:0] r_sum;
    logic               r_sign;
    logic signed [31:0] r_term;
    pee_pkg::t_term_op  r_pend;
    logic               r_ovf;
    logic               r_dz;

    // item and work registers
    logic signed [31:0] r_x;
    logic [2:0]         r_op;
    logic signed [63:0] r_prod;
    logic [DivW-1:0]    r_dq;
    logic [31:0]        r_dvs;
    logic [31:0]        r_rem;
    logic               r_neg;
    logic [CntW-1:0]    r_cnt;

    // result register
    logic               r_out_valid;
    logic signed [31:0] r_res;
    logic               r_res_ovf;
    logic               r_res_dz;

    logic [31:0]        mag_term;
    logic [31:0]        mag_x;
    logic signed [63:0] prod_sh;
    logic               mul_ovf;
    logic signed [31:0] mul_val;
    logic [32:0]        trial;
    logic [32:0]        diff;
    logic               qbit;
    logic               div_ovf;
    logic signed [31:0] div_val;
    logic signed [32:0] sum_wide;
    logic               sum_ovf;
    logic signed [31:0] sum_val;

    assign mag_term = r_term[31] ? unsigned'(-r_term) : unsigned'(r_term);
    assign mag_x    = r_x[31] ? unsigned'(-r_x) : unsigned'(r_x);

    // product scaled back by an arithmetic shift, which rounds toward minus infinity
    assign prod_sh = r_prod >>> FRAC_BITS;
    assign mul_ovf = !((&prod_sh[63:31]) || !(|prod_sh[63:31]));
    assign mul_val = mul_ovf ? (prod_sh[63] ? pee_pkg::SAT_MIN : pee_pkg::SAT_MAX)
                             : prod_sh[31:0];

    // restoring division, one quotient bit per cycle
    assign trial = {r_rem, r_dq[DivW-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign qbit  = !diff[32];

    always_comb begin
        if (r_neg) begin
            div_ovf = (|r_dq[DivW-1:32]) || (r_dq[31] && (|r_dq[30:0]));
            div_val = div_ovf ? pee_pkg::SAT_MIN : signed'(-r_dq[31:0]);
        end else begin
            div_ovf = |r_dq[DivW-1:31];
            div_val = div_ovf ? pee_pkg::SAT_MAX : signed'(r_dq[31:0]);
        end
    end

    assign sum_wide = r_sign ? (33'(r_sum) - 33'(r_term)) : (33'(r_sum) + 33'(r_term));
    assign sum_ovf  = sum_wide[32] != sum_wide[31];
    assign sum_val  = sum_ovf ? (sum_wide[32] ? pee_pkg::SAT_MIN : pee_pkg::SAT_MAX)
                              : sum_wide[31:0];

    always_comb begin
        o_status.pend     = r_pend;
        o_status.op       = r_op;
        o_status.x_zero   = (r_x == 32'sd0);
        o_status.div_last = (r_cnt == CntW'(DivW - 1));
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_sign      <= 1'b0;
            r_term      <= '0;
            r_pend      <= pee_pkg::TERM_LOAD;
            r_ovf       <= 1'b0;
            r_dz        <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.term_load) begin
                r_term <= r_x;
            end
            if (i_cmd.mul_fin) begin
                r_term <= mul_val;
                r_ovf  <= r_ovf | mul_ovf;
            end
            if (i_cmd.div_zero) begin
                r_term <= '0;
                r_dz   <= 1'b1;
            end
            if (i_cmd.div_start) begin
                r_cnt <= '0;
            end
            if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.div_fin) begin
                r_term <= div_val;
                r_ovf  <= r_ovf | div_ovf;
            end
            if (i_cmd.set_mul) begin
                r_pend <= pee_pkg::TERM_MUL;
            end
            if (i_cmd.set_div) begin
                r_pend <= pee_pkg::TERM_DIV;
            end
            if (i_cmd.fold_sum) begin
                r_sum  <= sum_val;
                r_ovf  <= r_ovf | sum_ovf;
                r_sign <= (r_op == pee_pkg::OP_SUB);
                r_pend <= pee_pkg::TERM_LOAD;
                r_term <= '0;
            end
            // drop all expression state once the result is captured
            if (i_cmd.emit) begin
                r_sum  <= '0;
                r_sign <= 1'b0;
                r_term <= '0;
                r_pend <= pee_pkg::TERM_LOAD;
                r_ovf  <= 1'b0;
                r_dz   <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_x  <= i_operand_value;
            r_op <= i_op_code;
        end
        if (i_cmd.mul_start) begin
            r_prod <= r_term * r_x;
        end
        if (i_cmd.div_start) begin
            r_dq  <= {mag_term, {FRAC_BITS{1'b0}}};
            r_dvs <= mag_x;
            r_rem <= '0;
            r_neg <= r_term[31] ^ r_x[31];
        end
        if (i_cmd.div_step) begin
            r_rem <= qbit ? diff[31:0] : trial[31:0];
            r_dq  <= {r_dq[DivW-2:0], qbit};
        end
        if (i_cmd.emit) begin
            r_res     <= sum_val;
            r_res_ovf <= r_ovf | sum_ovf;
            r_res_dz  <= r_dz;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_value  = r_res;
    assign o_overflow_flag = r_res_ovf;
    assign o_div_zero_flag = r_res_dz;

endmodule

/* src/pee_chk.sv */
// Port checker for the expression evaluator, bound to the top level.
`include "assert_macros.svh"

module pee_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [31:0] i_operand_value,
    input logic [2:0]  i_op_code,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_result_value,
    input logic        o_overflow_flag,
    input logic        o_div_zero_flag
);

    // a result item stays offered until taken
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "result item dropped before accept")

    // a stalled result item keeps its payload
    `ASSERT_RST(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_result_value) && $stable(o_overflow_flag) && $stable(o_div_zero_flag), "result payload changed while stalled")

    // reset leaves no result item behind
    `ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !o_out_valid, "result item present after reset")

    // an accepted item is worked on before the next one is taken
    `ASSERT_RST(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready, "item taken while previous item in work")

endmodule

bind precedence_expression_evaluator_core pee_chk u_pee_chk (.*);
